@@ src/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the sorted priority queue
// Operation and status codes, field widths and the cell command bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

    localparam int VALUE_W             = 32;
    localparam int STATUS_W            = 2;
    localparam int OCC_W               = 7;
    localparam int DEFAULT_QUEUE_DEPTH = 64;

    // operation codes (s_tuser)
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // command broadcast to every cell
    typedef struct packed {
        logic                      enq;
        logic                      deq;
        logic signed [VALUE_W-1:0] value;
    } cmd_t;

endpackage

`default_nettype wire

@@ src/spq_cell.sv @@
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted cell row
// Holds one entry; on enqueue keeps, takes the new value or shifts up from
// the left; on dequeue shifts down from the right.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell (
    input  wire                                     aclk,
    input  spq_pkg::cmd_t                           cmd,
    input  wire                                     occupied,
    input  wire  logic signed [spq_pkg::VALUE_W-1:0] left_val,
    input  wire                                     left_gt,
    input  wire  logic signed [spq_pkg::VALUE_W-1:0] right_val,
    output logic signed [spq_pkg::VALUE_W-1:0]      val,
    output logic                                    gt
);

    logic signed [spq_pkg::VALUE_W-1:0] val_reg;
    logic signed [spq_pkg::VALUE_W-1:0] val_next;

    // empty slots count as greater so the new value lands at the end
    assign gt  = !occupied || (val_reg > cmd.value);
    assign val = val_reg;

    always_comb begin
        val_next = val_reg;
        if (cmd.enq && gt) begin
            val_next = left_gt ? left_val : cmd.value;
        end else if (cmd.deq) begin
            val_next = right_val;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

endmodule

`default_nettype wire

@@ src/sorted_priority_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_queue: minimum-first priority queue on a sorted cell row
// Enqueue inserts after all entries <= value; dequeue removes the smallest.
// ----------------------------------------------------------------------------
// Result: registered; valid in the cycle after the input transaction is taken.
// Throughput: one transaction per cycle unless a held result blocks input;
//   every cell compares against the broadcast value and shifts in the same cycle.
// Backpressure: a single output register; input is taken while that register
//   is empty or being drained.
// Reset: synchronous, active-low aresetn clears the count and output valid;
//   cell contents are don't-care until written (count gates their use).
`default_nettype none

module sorted_priority_queue #(
    parameter int QUEUE_DEPTH = spq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  wire         aclk,
    input  wire         aresetn,
    // input channel
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,  // [31:0] value_in
    input  wire  [0:0]  s_tuser,  // [0] operation
    // result channel
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [47:0] m_tdata   // [31:0] value_out, [33:32] status,
                                  // [40:34] occupancy, [47:41] zero
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    logic                                    out_valid_reg;
    logic signed [spq_pkg::VALUE_W-1:0]      out_value_reg;
    logic signed [spq_pkg::VALUE_W-1:0]      out_value_next;
    logic [spq_pkg::STATUS_W-1:0]            out_status_reg;
    logic [spq_pkg::STATUS_W-1:0]            out_status_next;
    logic [spq_pkg::OCC_W-1:0]               out_occ_reg;
    logic [CW+spq_pkg::OCC_W-1:0]            occ_ext;

    logic in_fire;
    logic is_deq;
    logic full;
    logic empty;

    spq_pkg::cmd_t cmd;

    logic signed [spq_pkg::VALUE_W-1:0] cell_val [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]             cell_gt;
    logic [QUEUE_DEPTH-1:0]             cell_occ;

    // ---------------- handshake ----------------
    assign s_tready = !out_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;
    assign is_deq   = (s_tuser[0] == spq_pkg::OP_DEQUEUE);
    assign full     = (count_reg == CW'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);

    // ---------------- cell commands ----------------
    // full enqueue and empty dequeue leave the row untouched
    assign cmd.enq   = in_fire && !is_deq && !full;
    assign cmd.deq   = in_fire && is_deq && !empty;
    assign cmd.value = s_tdata[spq_pkg::VALUE_W-1:0];

    always_comb begin
        count_next      = count_reg;
        out_value_next  = '0;
        out_status_next = spq_pkg::ST_OK;
        if (in_fire) begin
            if (is_deq) begin
                if (empty) begin
                    out_status_next = spq_pkg::ST_EMPTY;
                end else begin
                    out_value_next = cell_val[0];
                    count_next     = count_reg - 1'b1;
                end
            end else begin
                if (full) begin
                    out_status_next = spq_pkg::ST_FULL;
                end else begin
                    count_next = count_reg + 1'b1;
                end
            end
        end
    end

    // occupancy wraps to its field width for deep queues
    assign occ_ext = {{spq_pkg::OCC_W{1'b0}}, count_next};

    // ---------------- cell row ----------------
    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
            logic signed [spq_pkg::VALUE_W-1:0] left_val;
            logic                               left_gt;
            logic signed [spq_pkg::VALUE_W-1:0] right_val;

            assign cell_occ[i] = (CW'(i) < count_reg);

            if (i == 0) begin : g_head
                assign left_val = '0;
                assign left_gt  = 1'b0;
            end else begin : g_mid
                assign left_val = cell_val[i-1];
                assign left_gt  = cell_gt[i-1];
            end

            if (i == QUEUE_DEPTH - 1) begin : g_tail
                assign right_val = cell_val[i];
            end else begin : g_body
                assign right_val = cell_val[i+1];
            end

            spq_cell u_cell (
                .aclk      (aclk),
                .cmd       (cmd),
                .occupied  (cell_occ[i]),
                .left_val  (left_val),
                .left_gt   (left_gt),
                .right_val (right_val),
                .val       (cell_val[i]),
                .gt        (cell_gt[i])
            );
        end
    endgenerate

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (in_fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            out_value_reg  <= out_value_next;
            out_status_reg <= out_status_next;
            out_occ_reg    <= occ_ext[spq_pkg::OCC_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_occ_reg, out_status_reg, out_value_reg};

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_empty_deq: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && is_deq && empty) |=>
            (out_status_reg == spq_pkg::ST_EMPTY && out_value_reg == '0))
        else $error("empty dequeue not flagged");

    a_enq_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && !is_deq && !full) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("enqueue did not grow the count");

    a_full_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && !is_deq && full) |=>
            (count_reg == $past(count_reg) && out_status_reg == spq_pkg::ST_FULL))
        else $error("full enqueue changed the queue");

    a_occ_match: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=>
            (({{spq_pkg::OCC_W{1'b0}}, count_reg} & {{CW{1'b0}}, {spq_pkg::OCC_W{1'b1}}})
                == {{CW{1'b0}}, out_occ_reg}))
        else $error("reported occupancy differs from count");

endmodule

`default_nettype wire

@@ tb/sv/sorted_priority_queue_tb.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_queue_tb: self-checking bench for the sorted priority queue
// Drives enqueue/dequeue transactions with random gaps and random result
// backpressure. A behavioral shadow queue predicts every result, and each
// result transaction is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = spq_pkg::DEFAULT_QUEUE_DEPTH;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 150;

    // value distributions for random traffic
    typedef enum int {
        VAL_FULL,    // any 32-bit pattern
        VAL_NARROW,  // tight range, lots of duplicates
        VAL_EDGE     // extremes around min, max and zero
    } value_mode_e;

    // one predicted result transaction
    typedef struct packed {
        logic signed [spq_pkg::VALUE_W-1:0] value;
        logic [spq_pkg::STATUS_W-1:0]       status;
        logic [spq_pkg::OCC_W-1:0]          occupancy;
    } reply_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [31:0] s_tdata  = '0;    // [31:0] value_in
    logic [0:0]  s_tuser  = '0;    // [0] operation
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [47:0] m_tdata;          // [31:0] value_out, [33:32] status,
                                   // [40:34] occupancy

    // shadow of the stored entries, ascending; equal values in arrival order
    logic signed [spq_pkg::VALUE_W-1:0] shadow_entries[$];
    // predicted results not yet seen on the result channel
    reply_t                             replies_due[$];

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    bit  tx_idle_on     = 1'b0;
    bit  rx_idle_on     = 1'b0;
    int  rx_hold        = 0;     // long receiver hold-off, in cycles
    int  rx_stall       = 0;     // remaining per-transaction receiver stall
    int  rx_gap;

    sorted_priority_queue #(
        .QUEUE_DEPTH(DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #6 aclk = ~aclk;

    // run-away guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t timeout after %0d cycles", $time, cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Prediction: apply one operation to the shadow queue, return the result.
    // ------------------------------------------------------------------------
    function automatic reply_t mirror_queue_op(logic op,
                                               logic signed [spq_pkg::VALUE_W-1:0] v);
        reply_t r;
        int     pos;
        r.value  = '0;
        r.status = spq_pkg::ST_OK;
        if (op == spq_pkg::OP_ENQUEUE) begin
            if (shadow_entries.size() >= DEPTH) begin
                r.status = spq_pkg::ST_FULL;      // dropped, store untouched
            end else begin
                // first stored entry strictly greater than the new value
                pos = 0;
                while (pos < shadow_entries.size() && shadow_entries[pos] <= v)
                    pos++;
                shadow_entries.insert(pos, v);
            end
        end else begin
            if (shadow_entries.size() == 0) begin
                r.status = spq_pkg::ST_EMPTY;     // nothing to hand out
            end else begin
                r.value = shadow_entries.pop_front();
            end
        end
        r.occupancy = spq_pkg::OCC_W'(shadow_entries.size());
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: optional random gap, then hold the transaction until accepted.
    // Valid stays high across back-to-back transactions.
    // ------------------------------------------------------------------------
    task automatic send_item(logic op, logic [31:0] v);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 9) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= v;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        replies_due.push_back(mirror_queue_op(op, v));
    endtask

    // sender goes quiet until every predicted result has come back
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (replies_due.size() != 0);
    endtask

    function automatic logic [31:0] pick_value(value_mode_e mode);
        logic [31:0] v;
        case (mode)
            VAL_NARROW: v = $urandom_range(0, 15) - 8;
            VAL_EDGE: begin
                case ($urandom_range(0, 5))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'h0000_0000;
                    3: v = 32'hFFFF_FFFF;
                    4: v = 32'h8000_0000 + $urandom_range(0, 3);
                    default: v = 32'h7FFF_FFFF - $urandom_range(0, 3);
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: per-transaction random stall, plus a long hold-off on request.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_stall <= 0;
        end else if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold  <= rx_hold - 1;
        end else if (rx_stall > 0) begin
            rx_stall <= rx_stall - 1;
        end else if (m_tready && m_tvalid && rx_idle_on) begin
            rx_gap = $urandom_range(0, 9);
            if (rx_gap != 0) begin
                m_tready <= 1'b0;
                rx_stall <= rx_gap - 1;
            end
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: every result transaction against the oldest prediction.
    // ------------------------------------------------------------------------
    task automatic check_reply(reply_t exp_r);
        logic signed [spq_pkg::VALUE_W-1:0] got_value;
        logic [spq_pkg::STATUS_W-1:0]       got_status;
        logic [spq_pkg::OCC_W-1:0]          got_occ;
        got_value  = m_tdata[31:0];
        got_status = m_tdata[33:32];
        got_occ    = m_tdata[40:34];
        if (got_value !== exp_r.value) begin
            $display("%0t ERROR value_out: expected %0d, actual %0d",
                     $time, exp_r.value, got_value);
            mismatch_count++;
        end
        if (got_status !== exp_r.status) begin
            $display("%0t ERROR status: expected %0d, actual %0d",
                     $time, exp_r.status, got_status);
            mismatch_count++;
        end
        if (got_occ !== exp_r.occupancy) begin
            $display("%0t ERROR occupancy: expected %0d, actual %0d",
                     $time, exp_r.occupancy, got_occ);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (replies_due.size() == 0) begin
                $display("%0t ERROR unexpected result: expected none, actual %h",
                         $time, m_tdata);
                mismatch_count++;
            end else begin
                check_reply(replies_due.pop_front());
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // dequeue on an empty store, right out of reset; value_in must not leak
    task automatic test_empty_dequeue();
        send_item(spq_pkg::OP_DEQUEUE, 32'h0000_0000);
        send_item(spq_pkg::OP_DEQUEUE, 32'hFFFF_FFFF);
        send_item(spq_pkg::OP_DEQUEUE, 32'h8000_0000);
    endtask

    // signed extremes in scrambled order, then drain past empty
    task automatic test_extreme_values();
        send_item(spq_pkg::OP_ENQUEUE, 32'h7FFF_FFFF);
        send_item(spq_pkg::OP_ENQUEUE, 32'h8000_0000);
        send_item(spq_pkg::OP_ENQUEUE, 32'h0000_0000);
        send_item(spq_pkg::OP_ENQUEUE, 32'hFFFF_FFFF);
        send_item(spq_pkg::OP_ENQUEUE, 32'h0000_0001);
        send_item(spq_pkg::OP_ENQUEUE, 32'hAAAA_5555);
        send_item(spq_pkg::OP_ENQUEUE, 32'h5555_AAAA);
        repeat (8) send_item(spq_pkg::OP_DEQUEUE, $urandom);
    endtask

    // equal values interleaved with neighbors, partial drain, refill, full drain
    task automatic test_equal_values();
        send_item(spq_pkg::OP_ENQUEUE, 32'd5);
        send_item(spq_pkg::OP_ENQUEUE, 32'd5);
        send_item(spq_pkg::OP_ENQUEUE, 32'hFFFF_FFFB);
        send_item(spq_pkg::OP_ENQUEUE, 32'd5);
        send_item(spq_pkg::OP_DEQUEUE, 32'd0);
        send_item(spq_pkg::OP_ENQUEUE, 32'hFFFF_FFFB);
        repeat (5) send_item(spq_pkg::OP_DEQUEUE, $urandom);
    endtask

    // fill to capacity, push past it, free and refill a slot, then empty and dequeue past empty
    task automatic test_fill_and_overflow(value_mode_e mode);
        repeat (DEPTH) send_item(spq_pkg::OP_ENQUEUE, pick_value(mode));
        repeat (3) send_item(spq_pkg::OP_ENQUEUE, pick_value(VAL_FULL));
        send_item(spq_pkg::OP_DEQUEUE, $urandom);
        send_item(spq_pkg::OP_ENQUEUE, pick_value(mode));
        send_item(spq_pkg::OP_ENQUEUE, pick_value(mode));
        repeat (DEPTH + 2) send_item(spq_pkg::OP_DEQUEUE, $urandom);
    endtask

    // mixed traffic; enq_pct biases the fill level toward full or empty
    task automatic test_random_traffic(int n, int enq_pct, value_mode_e mode);
        logic op;
        for (int i = 0; i < n; i++) begin
            op = ($urandom_range(0, 99) < enq_pct) ? spq_pkg::OP_ENQUEUE
                                                   : spq_pkg::OP_DEQUEUE;
            send_item(op, pick_value(mode));
        end
    endtask

    // receiver holds off for a long stretch while the sender keeps offering,
    // so the output register fills and input ready drops
    task automatic test_output_hold();
        rx_hold <= HOLD_CYCLES;
        repeat (10) send_item(1'($urandom_range(0, 1)), pick_value(VAL_NARROW));
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        int enq_bias[10];
        enq_bias = '{85, 50, 15, 70, 30, 95, 5, 50, 60, 40};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_dequeue();
        test_extreme_values();
        test_equal_values();
        wait_results_drained();

        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        test_fill_and_overflow(VAL_NARROW);
        wait_results_drained();

        test_output_hold();
        wait_results_drained();

        for (int p = 0; p < 10; p++) begin
            // stretches with no idling on one or both sides
            tx_idle_on = (p % 4 != 3) && (p % 4 != 2);
            rx_idle_on = (p % 4 != 3) && (p % 4 != 1);
            test_random_traffic(190, enq_bias[p], value_mode_e'(p % 3));
            if (p % 3 == 2)
                wait_results_drained();
        end

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (replies_due.size() != 0);
        // let any stray result transaction show up
        repeat (20) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
src/spq_pkg.sv
src/spq_cell.sv
src/sorted_priority_queue.sv
tb/sv/sorted_priority_queue_tb.sv
